// ===== hdl/lwm_pkg.sv =====
// Shared definitions for the LIKE wildcard matcher: request codes, wildcard bytes,
// the default pattern capacity and the control bundle broadcast to the cell row.
// No dependencies.
package lwm_pkg;

	localparam int PATTERN_MAX_DEF = 32;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_TEXT   = 2'd2;
	localparam logic [1:0] REQ_FINISH = 2'd3;

	localparam logic [7:0] ANY_RUN = 8'h25;
	localparam logic [7:0] ANY_ONE = 8'h5F;

	// Decoded request of the accepted beat, one copy seen by every cell.
	typedef struct packed {
		logic       clear;
		logic       append;     // append that fits; a dropped byte never shows here
		logic       text;
		logic       restart;
		logic [7:0] byte_value;
	} lwm_ctrl_t;

endpackage

// ===== hdl/like_wildcard_matcher.sv =====
// SQL LIKE matcher over a streamed text: a row of lwm_cell instances plus the
// terminal position, request decode and the result register.
// Depends on lwm_pkg and lwm_cell.
//
// Usage: each input beat carries a request in s_tuser and a byte in s_tdata.
// Clear empties the pattern; append adds one pattern byte ('%' matches any run,
// '_' any single byte); text feeds one text byte; finish emits one result beat
// (matched, pattern_overflow) and restarts the text against the same pattern.
// Append and clear also restart the text. Bytes appended beyond PATTERN_MAX are
// dropped and set pattern_overflow until the next clear.
// Throughput is one beat per cycle for every request type: each text byte moves
// all active positions through the whole cell row, the '%' closure
// rippling through the row like a carry. The result of a finish beat appears on
// m_tvalid in the next cycle. A pending result blocks input only while the
// receiver holds m_tready low; s_tready is low exactly then.
// After reset the pattern is empty, the overflow flag clear and no result pending.
module like_wildcard_matcher import lwm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_value
	input  logic [1:0] s_tuser,   // [1:0] req_type
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

	lwm_ctrl_t ctrl;
	logic      accept;
	logic      finish;
	logic      full;
	logic      overflow_q;
	logic      term_act_q;
	logic      term_end_q;
	logic      term_closed;
	logic      matched;
	logic      m_tvalid_q;
	logic [1:0] m_bits_q;

	logic [PATTERN_MAX:0]   carry;
	logic [PATTERN_MAX:0]   step;
	logic [PATTERN_MAX:0]   ends;
	logic [PATTERN_MAX-1:0] valids;
	logic [PATTERN_MAX:0]   hits;

	assign s_tready = ~m_tvalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;
	assign full     = term_end_q;

	always_comb begin
		ctrl            = '0;
		ctrl.byte_value = s_tdata;
		finish          = 1'b0;
		if (accept) begin
			unique case (s_tuser)
				REQ_CLEAR: begin
					ctrl.clear   = 1'b1;
					ctrl.restart = 1'b1;
				end
				REQ_APPEND: begin
					ctrl.append  = ~full;
					ctrl.restart = 1'b1;
				end
				REQ_TEXT: begin
					ctrl.text = 1'b1;
				end
				REQ_FINISH: begin
					ctrl.restart = 1'b1;
					finish       = 1'b1;
				end
				default: begin
					ctrl.restart = 1'b1;
				end
			endcase
		end
	end

	assign carry[0] = 1'b0;
	assign step[0]  = 1'b0;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		lwm_cell #(
			.FIRST (i == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.step_in   (step[i]),
			.end_in    ((i == 0) ? 1'b0 : ends[(i == 0) ? 0 : i - 1]),
			.carry_out (carry[i+1]),
			.step_out  (step[i+1]),
			.end_out   (ends[i]),
			.valid_out (valids[i]),
			.hit       (hits[i])
		);
	end

	// Terminal position: the whole pattern consumed, no byte of its own.
	assign term_closed         = term_act_q | carry[PATTERN_MAX];
	assign ends[PATTERN_MAX]   = term_end_q;
	assign hits[PATTERN_MAX]   = term_closed & term_end_q;
	assign matched             = |hits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_act_q <= 1'b0;
			term_end_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				term_end_q <= 1'b0;
			end else if (ctrl.append) begin
				term_end_q <= ends[PATTERN_MAX-1];
			end
			if (ctrl.restart) begin
				term_act_q <= 1'b0;
			end else if (ctrl.text) begin
				term_act_q <= step[PATTERN_MAX];
			end
			if (ctrl.clear) begin
				overflow_q <= 1'b0;
			end else if (accept && s_tuser == REQ_APPEND && full) begin
				overflow_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_bits_q <= {overflow_q, matched};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, m_bits_q};

	// The end marker sits at exactly one position at all times.
	a_end_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(ends))
		else $error("pattern end marker is not one-hot");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> (valids == '0) && ends[0] && !overflow_q)
		else $error("clear left pattern bytes or overflow behind");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> m_tvalid_q)
		else $error("finish beat produced no result");

	a_overflow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> $past(full))
		else $error("overflow flagged while the pattern store had room");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !ctrl.append)
		else $error("pattern byte written past capacity");

endmodule

// ===== hdl/lwm_cell.sv =====
// One pattern position of the LIKE matcher: pattern byte, length marker bits and
// the active bit of the position, chained to its neighbors. Depends on lwm_pkg.
module lwm_cell import lwm_pkg::*; #(
	parameter bit FIRST = 1'b0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  lwm_ctrl_t ctrl,
	input  logic      carry_in,   // previous position reached and it is a '%'
	input  logic      step_in,    // previous position consumed the text byte
	input  logic      end_in,     // previous position holds the end marker
	output logic      carry_out,
	output logic      step_out,
	output logic      end_out,
	output logic      valid_out,
	output logic      hit
);

	logic [7:0] pat_q;
	logic       valid_q;
	logic       end_q;
	logic       act_q;
	logic       closed;
	logic       is_run;

	assign is_run    = (pat_q == ANY_RUN);
	assign closed    = act_q | carry_in;
	assign carry_out = closed & valid_q & is_run;
	assign step_out  = closed & valid_q & ~is_run &
		((pat_q == ctrl.byte_value) | (pat_q == ANY_ONE));
	assign end_out   = end_q;
	assign valid_out = valid_q;
	assign hit       = closed & end_q;

	always_ff @(posedge clk) begin
		if (ctrl.append && end_q) begin
			pat_q <= ctrl.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			end_q   <= FIRST;
			act_q   <= FIRST;
		end else begin
			if (ctrl.clear) begin
				valid_q <= 1'b0;
				end_q   <= FIRST;
			end else if (ctrl.append) begin
				// The end marker moves one position up as the byte lands here.
				if (end_q) begin
					valid_q <= 1'b1;
				end
				end_q <= end_in;
			end
			if (ctrl.restart) begin
				act_q <= FIRST;
			end else if (ctrl.text) begin
				act_q <= step_in | carry_out;
			end
		end
	end

endmodule

// ===== verif/tb_like_wildcard_matcher.sv =====
// Self-checking testbench for like_wildcard_matcher: builds LIKE patterns, streams texts
// against them and checks every finish result against an in-bench matcher model.
// Depends on lwm_pkg and the like_wildcard_matcher RTL.
module tb_like_wildcard_matcher import lwm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAT_MAX     = PATTERN_MAX_DEF;
	localparam int N_RANDOM    = 1750;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 400;

	localparam logic [PAT_MAX:0] LIVE_START = {{PAT_MAX{1'b0}}, 1'b1};

	typedef struct {
		logic [1:0] req;
		logic [7:0] data;
		int         gap;
		bit         drain;
	} like_req_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] byte_value
	logic [1:0] s_tuser = REQ_CLEAR;   // [1:0] req_type
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;   // [0] matched, [1] pattern_overflow, [7:2] zero

	like_req_t  req_queue[$];
	verdict_t   verdict_queue[$];
	int         n_items = 0;
	int         n_accepted = 0;
	int         n_verdicts_due = 0;
	int         n_verdicts_seen = 0;
	int         n_errors = 0;
	bit         tx_fast = 1'b0;
	bit         rx_fast = 1'b0;
	bit         drain_next = 1'b0;

	// Matcher model state.
	logic [7:0]       pat_mem [PAT_MAX];
	int               pat_len = 0;
	logic             pat_ovf = 1'b0;
	logic [PAT_MAX:0] live_pos = LIVE_START;

	// Driver and monitor state.
	int        gap_left = 0;
	bit        gap_armed = 1'b0;
	logic      offer;
	like_req_t cur_req;
	int        rx_wait = 0;
	logic      take;
	verdict_t  want;
	int        rx_hold_left = 0;
	bit        rx_hold_done = 1'b0;

	like_wildcard_matcher #(.PATTERN_MAX(PAT_MAX)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	task automatic like_step(input logic [1:0] req, input logic [7:0] b);
		logic [PAT_MAX:0] cur;
		logic [PAT_MAX:0] nxt;
		verdict_t v;
		// A '%' may match the empty run, so it passes its position on unchanged.
		cur = live_pos;
		for (int i = 0; i < pat_len; i++)
			if (cur[i] && pat_mem[i] == ANY_RUN) cur[i + 1] = 1'b1;
		case (req)
			REQ_CLEAR: begin
				pat_len = 0;
				pat_ovf = 1'b0;
				live_pos = LIVE_START;
			end
			REQ_APPEND: begin
				if (pat_len < PAT_MAX) begin
					pat_mem[pat_len] = b;
					pat_len++;
				end else begin
					pat_ovf = 1'b1;
				end
				live_pos = LIVE_START;
			end
			REQ_TEXT: begin
				nxt = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (cur[i]) begin
						if (pat_mem[i] == ANY_RUN) nxt[i] = 1'b1;
						else if (pat_mem[i] == ANY_ONE || pat_mem[i] == b) nxt[i + 1] = 1'b1;
					end
				end
				live_pos = nxt;
			end
			REQ_FINISH: begin
				v.matched = cur[pat_len];
				v.overflow = pat_ovf;
				verdict_queue = {verdict_queue, v};
				n_verdicts_due++;
				live_pos = LIVE_START;
			end
		endcase
	endtask

	function automatic void push_req(input logic [1:0] req, input logic [7:0] data);
		like_req_t it;
		// Alternate between stretches without gaps and stretches with random gaps.
		if (n_items % 150 == 0) tx_fast = ($urandom_range(0, 2) == 0);
		it.req = req;
		it.data = data;
		it.gap = tx_fast ? 0 : $urandom_range(0, 5);
		it.drain = drain_next;
		drain_next = 1'b0;
		req_queue = {req_queue, it};
		n_items++;
	endfunction

	function automatic logic [7:0] pick_pat_byte();
		case ($urandom_range(0, 9))
			0, 1: return ANY_RUN;
			2: return ANY_ONE;
			3, 4, 5: return 8'h61;
			6, 7: return 8'h62;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 9))
			0: return ANY_RUN;
			1: return ANY_ONE;
			2, 3, 4, 5: return 8'h61;
			6, 7: return 8'h62;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Sender: one beat in flight, a drawn gap before each, optional drain before it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			n_accepted <= 0;
			gap_left = 0;
			gap_armed = 1'b0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				like_step(s_tuser, s_tdata);
				n_accepted <= n_accepted + 1;
				offer = 1'b0;
			end
			if (!offer && req_queue.size() != 0) begin
				if (!gap_armed) begin
					gap_left = req_queue[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else if (!req_queue[0].drain || n_verdicts_due == n_verdicts_seen) begin
					cur_req = req_queue.pop_front();
					s_tuser <= cur_req.req;
					s_tdata <= cur_req.data;
					offer = 1'b1;
					gap_armed = 1'b0;
				end
			end
			s_tvalid <= offer;
		end
	end

	// Long receiver hold-off once traffic is under way, so the result slot fills.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			rx_hold_done <= 1'b0;
		end else if (!rx_hold_done && n_accepted >= HOLD_AT) begin
			rx_hold_left <= HOLD_CYCLES;
			rx_hold_done <= 1'b1;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			n_verdicts_seen <= 0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_queue.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: result beat with nothing expected, got %b", $realtime,
							m_tdata[1:0]);
				end else begin
					want = verdict_queue.pop_front();
					if (m_tdata[0] !== want.matched || m_tdata[1] !== want.overflow) begin
						n_errors++;
						if (n_errors <= 10)
							$display("%0t: result %0d expected matched=%b overflow=%b, got %b %b",
								$realtime, n_verdicts_seen, want.matched, want.overflow,
								m_tdata[0], m_tdata[1]);
					end
				end
				n_verdicts_seen <= n_verdicts_seen + 1;
				if (n_verdicts_seen % 40 == 0) rx_fast = ($urandom_range(0, 2) == 0);
				rx_wait = rx_fast ? 0 : $urandom_range(0, 5);
			end
			if (rx_hold_left != 0) begin
				take = 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
			m_tready <= take;
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int plen;
		int tlen;
		int seq;
		int k;
		logic [7:0] pat[$];
		logic [7:0] txt[$];

		// Directed: empty pattern and text, all-'%' pattern, '%' against a literal
		// '%', case, '_' on any byte, append and clear in the middle of a text.
		push_req(REQ_FINISH, 8'hFF);
		push_req(REQ_TEXT, 8'h61);
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_CLEAR, 8'hFF);
		push_req(REQ_APPEND, ANY_RUN);
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_APPEND, 8'h41);
		push_req(REQ_TEXT, ANY_RUN);
		push_req(REQ_TEXT, 8'h41);
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_TEXT, 8'h61);
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_APPEND, ANY_ONE);
		push_req(REQ_TEXT, 8'h41);
		push_req(REQ_TEXT, 8'h00);
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_TEXT, 8'h41);
		push_req(REQ_APPEND, 8'hFF);
		push_req(REQ_TEXT, 8'h41);
		push_req(REQ_TEXT, ANY_ONE);
		push_req(REQ_TEXT, 8'hFF);
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_TEXT, 8'h41);
		push_req(REQ_CLEAR, 8'h00);
		push_req(REQ_FINISH, 8'h00);

		seq = 0;
		while (n_items < N_RANDOM + 25) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				// Mostly short patterns; now and then one past the capacity.
				plen = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 36) : $urandom_range(0, 8);
				if (seq == 0) plen = PAT_MAX + 2;
				if (seq % 25 == 7) drain_next = 1'b1;
				push_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
				pat.delete();
				repeat (plen) pat = {pat, pick_pat_byte()};
				foreach (pat[j]) push_req(REQ_APPEND, pat[j]);
				repeat ($urandom_range(1, 4)) begin
					txt.delete();
					if ($urandom_range(0, 2) != 0) begin
						// Text built to fit the stored part of the pattern, sometimes spoiled.
						for (k = 0; k < pat.size() && k < PAT_MAX; k++) begin
							if (pat[k] == ANY_RUN) repeat ($urandom_range(0, 3))
								txt = {txt, pick_text_byte()};
							else if (pat[k] == ANY_ONE) txt = {txt, pick_text_byte()};
							else txt = {txt, pat[k]};
						end
						if ($urandom_range(0, 4) == 0 && txt.size() != 0)
							txt[$urandom_range(0, txt.size() - 1)] = pick_text_byte();
					end else begin
						tlen = $urandom_range(0, 8);
						repeat (tlen) txt = {txt, pick_text_byte()};
					end
					foreach (txt[j]) push_req(REQ_TEXT, txt[j]);
					push_req(REQ_FINISH, 8'($urandom_range(0, 255)));
				end
				seq++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_accepted == n_items);
		wait (n_verdicts_seen == n_verdicts_due);
		repeat (8) @(posedge clk);
		if (n_errors == 0 && verdict_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lwm_pkg.sv
hdl/lwm_cell.sv
hdl/like_wildcard_matcher.sv
verif/tb_like_wildcard_matcher.sv
